/* sv/deq_pkg.sv */
// Shared types and constants for the double-ended queue block.
// No dependencies; used by deq_front, deq_back and double_ended_queue.
package deq_pkg;

  localparam int Capacity = 64;
  localparam int DataW    = 32;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int ModeW    = 3;

  // Operation codes match the mode field encoding.
  typedef enum logic [ModeW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } back_state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
  } cmd_t;

  // Ring position step forward and back, wrapping at the capacity.
  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] pos);
    logic [IdxW-1:0] res;
    if (pos == IdxW'(Capacity - 1)) res = '0;
    else                            res = pos + IdxW'(1);
    return res;
  endfunction

  function automatic logic [IdxW-1:0] ring_dec(input logic [IdxW-1:0] pos);
    logic [IdxW-1:0] res;
    if (pos == '0) res = IdxW'(Capacity - 1);
    else           res = pos - IdxW'(1);
    return res;
  endfunction

endpackage

/* sv/double_ended_queue.sv */
// Top level of the double-ended queue: front end plus back end.
// Depends on deq_pkg, deq_front and deq_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per command:
//   mode_i (0 push front, 1 push back, 2 pop front, 3 pop back, 4 list) and
//   value_i. Modes 5..7 are taken and dropped with no result.
//   Output channel (out_valid_o / out_stall_i) returns result words: status_o,
//   has_element_o, element_o and last_o, which marks the final word of a command.
//   A push or pop result passes through the command queue and then the output
//   register. The back end takes a push or pop while the output is free; a
//   listing makes one ring store read per cycle while the output is free, after
//   taking the list command, until each stored entry has been fetched.
//   A two-entry command queue lets input words arrive while the back end
//   lists or the receiver stalls.
//   Reset clears the front index, count and all valid flags; the ring store
//   is not cleared and needs no clearing pass.
//   When the receiver holds out_stall_i, the output word holds, the back
//   end stops, and in_stall_o rises once the command queue fills.
module double_ended_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::ModeW-1:0]         mode_i,
  input  logic signed [deq_pkg::DataW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic                              has_element_o,
  output logic signed [deq_pkg::DataW-1:0]  element_o,
  output logic                              last_o
);

  logic          cmd_valid;
  logic          cmd_take;
  deq_pkg::cmd_t cmd;

  // Accept and classify words, buffer commands.
  deq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Execute commands against the ring store and drive result words.
  deq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_take_o    (cmd_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .has_element_o (has_element_o),
    .element_o     (element_o),
    .last_o        (last_o)
  );

endmodule

/* sv/deq_front.sv */
// Front end of the double-ended queue: accepts words, classifies the mode
// and holds commands in a two-entry queue. Depends on deq_pkg.
module deq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::ModeW-1:0]         mode_i,
  input  logic signed [deq_pkg::DataW-1:0]  value_i,
  output logic                              cmd_valid_o,
  output deq_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_take_i
);

  deq_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q, fill_d;
  logic          known_op, push, pop;
  deq_pkg::cmd_t new_cmd;

  // Drop unused modes: accepted, never queued.
  always_comb begin
    known_op = 1'b1;
    case (mode_i)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK, deq_pkg::OP_POP_FRONT,
      deq_pkg::OP_POP_BACK, deq_pkg::OP_LIST: known_op = 1'b1;
      default: known_op = 1'b0;
    endcase
    new_cmd.op    = deq_pkg::op_e'(mode_i);
    new_cmd.value = value_i;
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && known_op;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign pop         = cmd_take_i && cmd_valid_o;

  always_comb begin
    fill_d = fill_q;
    if (push && !pop)      fill_d = fill_q + 2'd1;
    else if (!push && pop) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= new_cmd;
  end

endmodule

/* sv/deq_back.sv */
// Back end of the double-ended queue: ring store, front index and count,
// list sequencer and output register. Depends on deq_pkg.
module deq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  deq_pkg::cmd_t                     cmd_i,
  output logic                              cmd_take_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic                              has_element_o,
  output logic signed [deq_pkg::DataW-1:0]  element_o,
  output logic                              last_o
);

  localparam logic [deq_pkg::CntW-1:0] CapCnt = deq_pkg::CntW'(deq_pkg::Capacity);

  logic signed [deq_pkg::DataW-1:0] mem [deq_pkg::Capacity];

  deq_pkg::back_state_e       state_q, state_d;
  logic [deq_pkg::IdxW-1:0]   front_q, front_d;
  logic [deq_pkg::CntW-1:0]   count_q, count_d;
  logic [deq_pkg::IdxW-1:0]   rd_pos_q, rd_pos_d;
  logic [deq_pkg::CntW-1:0]   left_q, left_d;
  logic                       rd_v_q, rd_v_d;
  logic                       rd_last_q, rd_last_d;
  logic signed [deq_pkg::DataW-1:0] rdata_q;

  logic                       out_vld_q, out_vld_d;
  logic [1:0]                 status_q;
  logic                       has_q, last_q;
  logic signed [deq_pkg::DataW-1:0] elem_q;

  logic                       out_free, out_load, rd_en, wr_en, ld_out;
  logic [deq_pkg::IdxW-1:0]   wr_addr;
  logic [deq_pkg::CntW-1:0]   back_sum;
  logic [1:0]                 o_status;
  logic                       o_has, o_last;
  logic signed [deq_pkg::DataW-1:0] o_elem;

  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = rd_v_q && out_free;
  assign back_sum = {1'b0, front_q} + count_q;

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    rd_pos_d   = rd_pos_q;
    left_d     = left_q;
    rd_v_d     = rd_v_q;
    rd_last_d  = rd_last_q;
    cmd_take_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = front_q;
    rd_en      = 1'b0;
    ld_out     = 1'b0;
    o_status   = deq_pkg::STATUS_OK;
    o_has      = 1'b0;
    o_elem     = '0;
    o_last     = 1'b1;
    case (state_q)
      deq_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_take_o = 1'b1;
          ld_out     = 1'b1;
          case (cmd_i.op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              if (count_q >= CapCnt) begin
                o_status = deq_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + deq_pkg::CntW'(1);
                if (cmd_i.op == deq_pkg::OP_PUSH_FRONT) begin
                  front_d = deq_pkg::ring_dec(front_q);
                  wr_addr = front_d;
                end else if (back_sum >= CapCnt) begin
                  wr_addr = deq_pkg::IdxW'(back_sum - CapCnt);
                end else begin
                  wr_addr = back_sum[deq_pkg::IdxW-1:0];
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (count_q == '0) begin
                o_status = deq_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - deq_pkg::CntW'(1);
                if (cmd_i.op == deq_pkg::OP_POP_FRONT) front_d = deq_pkg::ring_inc(front_q);
              end
            end
            deq_pkg::OP_LIST: begin
              if (count_q == '0) begin
                o_status = deq_pkg::STATUS_EMPTY;
              end else begin
                ld_out   = 1'b0;
                state_d  = deq_pkg::BK_LIST;
                rd_pos_d = front_q;
                left_d   = count_q;
              end
            end
            default: ld_out = 1'b0;
          endcase
        end
      end
      deq_pkg::BK_LIST: begin
        // Hand the fetched entry to the output, then fetch the next one.
        if (out_load) begin
          ld_out   = 1'b1;
          o_has    = 1'b1;
          o_elem   = rdata_q;
          o_last   = rd_last_q;
          rd_v_d   = 1'b0;
        end
        if (!rd_v_q || out_load) begin
          if (left_q != '0) begin
            rd_en     = 1'b1;
            rd_v_d    = 1'b1;
            rd_last_d = (left_q == deq_pkg::CntW'(1));
            left_d    = left_q - deq_pkg::CntW'(1);
            rd_pos_d  = deq_pkg::ring_inc(rd_pos_q);
          end else begin
            state_d = deq_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = deq_pkg::BK_IDLE;
    endcase

    out_vld_d = out_vld_q;
    if (ld_out)           out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= deq_pkg::BK_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      rd_pos_q  <= '0;
      left_q    <= '0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      rd_pos_q  <= rd_pos_d;
      left_q    <= left_d;
      rd_v_q    <= rd_v_d;
      rd_last_q <= rd_last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= cmd_i.value;
    if (rd_en) rdata_q <= mem[rd_pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      status_q <= o_status;
      has_q    <= o_has;
      elem_q   <= o_elem;
      last_q   <= o_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign has_element_o = has_q;
  assign element_o     = elem_q;
  assign last_o        = last_q;

endmodule

/* test/tb.sv */
// Self-checking bench for double_ended_queue: drives push, pop and list words
// and checks each result word against an in-bench mirror of the ring store.
// Depends on deq_pkg and double_ended_queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Modes above the list code are taken and dropped by the block.
  localparam logic [deq_pkg::ModeW-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [deq_pkg::ModeW-1:0] MODE_SPARE_HI = 3'd7;
  localparam int ItemTarget  = 220;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 20;
  localparam int LongHold    = 300;

  typedef struct packed {
    logic [deq_pkg::ModeW-1:0]        mode;
    logic signed [deq_pkg::DataW-1:0] value;
  } deque_cmd_t;

  typedef struct packed {
    deq_pkg::status_e                 status;
    logic                             has;
    logic signed [deq_pkg::DataW-1:0] elem;
    logic                             last;
  } deque_result_t;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic [deq_pkg::ModeW-1:0]        mode_i      = '0;
  logic signed [deq_pkg::DataW-1:0] value_i     = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [1:0]                       status_o;
  logic                             has_element_o;
  logic signed [deq_pkg::DataW-1:0] element_o;
  logic                             last_o;

  double_ended_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .has_element_o (has_element_o),
    .element_o     (element_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Command words waiting for the sender, and result words still owed.
  deque_cmd_t    cmd_backlog [$];
  deque_result_t due_results [$];

  // Mirror of the block state, advanced once per accepted command word.
  logic signed [deq_pkg::DataW-1:0] mirror_store [deq_pkg::Capacity];
  logic [deq_pkg::IdxW-1:0]         mirror_front = '0;
  logic [deq_pkg::CntW-1:0]         mirror_count = '0;

  // Occupancy as seen while building the stimulus, so fill and drain runs
  // can aim at the full and empty edges.
  int gen_count    = 0;
  int gen_items    = 0;
  int words_total  = 0;
  int words_sent   = 0;
  int fail_count   = 0;

  // Handshake flags: set at the rising edge, consumed at the falling edge.
  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;
  bit hold_long    = 1'b0;
  int tx_wait      = 0;
  int rx_wait      = 0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;

  // Work out the result words of one command and update the mirror.
  function automatic void predict_deque(input logic [deq_pkg::ModeW-1:0] mode,
                                        input logic signed [deq_pkg::DataW-1:0] value);
    int n;
    case (mode)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (mirror_count == deq_pkg::Capacity) begin
          // Full: refuse the push and leave the ring untouched.
          due_results.push_back('{deq_pkg::STATUS_FULL, 1'b0, 32'sd0, 1'b1});
        end else begin
          if (mode == deq_pkg::OP_PUSH_FRONT) begin
            mirror_front = mirror_front - 1'b1;
            mirror_store[mirror_front] = value;
          end else begin
            mirror_store[deq_pkg::IdxW'(mirror_front + mirror_count)] = value;
          end
          mirror_count = mirror_count + 1'b1;
          due_results.push_back('{deq_pkg::STATUS_OK, 1'b0, 32'sd0, 1'b1});
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (mirror_count == 0) begin
          due_results.push_back('{deq_pkg::STATUS_EMPTY, 1'b0, 32'sd0, 1'b1});
        end else begin
          if (mode == deq_pkg::OP_POP_FRONT) mirror_front = mirror_front + 1'b1;
          mirror_count = mirror_count - 1'b1;
          due_results.push_back('{deq_pkg::STATUS_OK, 1'b0, 32'sd0, 1'b1});
        end
      end
      deq_pkg::OP_LIST: begin
        if (mirror_count == 0) begin
          due_results.push_back('{deq_pkg::STATUS_EMPTY, 1'b0, 32'sd0, 1'b1});
        end else begin
          // One word per entry, front to back; mark the final one.
          for (n = 0; n < mirror_count; n++) begin
            due_results.push_back('{deq_pkg::STATUS_OK, 1'b1,
                                    mirror_store[deq_pkg::IdxW'(mirror_front + n)],
                                    n == mirror_count - 1});
          end
        end
      end
      default: ;  // spare modes: no result, no state change
    endcase
  endfunction

  // Append a command word and track the occupancy it leads to.
  function automatic void queue_cmd(input logic [deq_pkg::ModeW-1:0] mode,
                                    input logic signed [deq_pkg::DataW-1:0] value);
    cmd_backlog.push_back('{mode, value});
    words_total++;
    case (mode)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
        if (gen_count < deq_pkg::Capacity) gen_count++;
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
        if (gen_count > 0) gen_count--;
      default: ;
    endcase
    if (mode <= deq_pkg::OP_LIST) gen_items++;
  endfunction

  // Favor the value extremes, otherwise any 32-bit pattern.
  function automatic logic signed [deq_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [deq_pkg::ModeW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return deq_pkg::OP_PUSH_FRONT;
    if (r < 44) return deq_pkg::OP_PUSH_BACK;
    if (r < 61) return deq_pkg::OP_POP_FRONT;
    if (r < 78) return deq_pkg::OP_POP_BACK;
    if (r < 92) return deq_pkg::OP_LIST;
    return deq_pkg::ModeW'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endfunction

  // Sender: present one command word at a time from the backlog, hold it
  // until taken, then wait the drawn gap before the next one.
  always @(negedge clk_i) begin : sender
    logic       offer;
    deque_cmd_t c;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_taken) begin
        offer    = 1'b0;
        in_taken = 1'b0;
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (cmd_backlog.size() != 0) begin
          c = cmd_backlog.pop_front();
          mode_i  <= c.mode;
          value_i <= c.value;
          offer    = 1'b1;
          // Switch between gappy stretches and back-to-back stretches.
          if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
          tx_wait = tx_quiet ? 0 : $urandom_range(0, 15);
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: after each taken result word, stall for a drawn number of
  // cycles; the long hold overrides everything while it lasts.
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= hold_long || (rx_wait > 0);
    end
  end

  // Long hold-off: let the command queue fill so the block stalls its input
  // while the sender keeps offering words.
  initial begin : long_hold
    while (words_sent < 40) @(posedge clk_i);
    hold_long = 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_long = 1'b0;
  end

  // Monitor: check taken result words first, then predict for a taken
  // command word; a command never answers at the edge it is taken.
  always @(posedge clk_i) begin : monitor
    deque_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected result word: status %0d has %0b element %0d last %0b",
                     status_o, has_element_o, element_o, last_o);
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status || has_element_o !== want.has ||
              element_o !== want.elem || last_o !== want.last) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display({"result mismatch: expected status %0d has %0b element %0d ",
                        "last %0b, got status %0d has %0b element %0d last %0b"},
                       want.status, want.has, want.elem, want.last,
                       status_o, has_element_o, element_o, last_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        words_sent++;
        predict_deque(mode_i, value_i);
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int  m;
    bit  first_seg;

    // Directed opening: empty-queue cases, value extremes, front wrap of the
    // ring, every operation, and the spare modes.
    queue_cmd(deq_pkg::OP_LIST, 32'sd0);
    queue_cmd(deq_pkg::OP_POP_FRONT, 32'sh7fffffff);
    queue_cmd(deq_pkg::OP_POP_BACK, -32'sd1);
    queue_cmd(deq_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
    queue_cmd(deq_pkg::OP_PUSH_BACK, 32'sh80000000);
    queue_cmd(deq_pkg::OP_PUSH_FRONT, -32'sd1);
    queue_cmd(deq_pkg::OP_PUSH_BACK, 32'sd0);
    queue_cmd(deq_pkg::OP_LIST, 32'sd0);
    queue_cmd(deq_pkg::OP_POP_FRONT, -32'sd1);
    queue_cmd(deq_pkg::OP_LIST, 32'sh55555555);
    queue_cmd(deq_pkg::OP_POP_BACK, 32'shaaaaaaaa);
    queue_cmd(deq_pkg::OP_LIST, 32'sd0);
    for (m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      queue_cmd(deq_pkg::ModeW'(m), $urandom());
    queue_cmd(deq_pkg::OP_LIST, 32'sd0);
    queue_cmd(deq_pkg::OP_POP_FRONT, 32'sd0);
    queue_cmd(deq_pkg::OP_POP_BACK, 32'sd0);
    queue_cmd(deq_pkg::OP_POP_BACK, 32'sd0);
    queue_cmd(deq_pkg::OP_LIST, -32'sd1);

    // Random part: fill runs that hit the full edge, drain runs that hit
    // the empty edge, and loose mixes in between.  Start with a fill so the
    // full case is always reached.
    first_seg = 1'b1;
    while (gen_items < ItemTarget) begin
      case (first_seg ? 0 : $urandom_range(0, 3))
        0: begin
          while (gen_count < deq_pkg::Capacity)
            queue_cmd($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                      pick_value());
          repeat ($urandom_range(1, 2)) queue_cmd(deq_pkg::OP_PUSH_BACK, pick_value());
          queue_cmd(deq_pkg::OP_PUSH_FRONT, pick_value());
          queue_cmd(deq_pkg::OP_LIST, pick_value());
        end
        1: begin
          while (gen_count > 0)
            queue_cmd($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                      pick_value());
          queue_cmd($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                    pick_value());
          queue_cmd(deq_pkg::OP_LIST, pick_value());
        end
        default: begin
          repeat ($urandom_range(4, 16)) queue_cmd(pick_op(), pick_value());
        end
      endcase
      first_seg = 1'b0;
    end

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every result to come back, then
    // watch a little longer for stray result words.
    while (words_sent < words_total) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
